FILE: rtl/core/irrigation_zone_power_controller_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the irrigation zone power controller
// ---------------------------------------------------------------------------
`ifndef IRRIGATION_ZONE_POWER_CONTROLLER_DEFINES_SVH
`define IRRIGATION_ZONE_POWER_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define IZPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("izpc assertion failed");
// check a property on every clock edge, reset included
`define IZPC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("izpc assertion failed");
`else
`define IZPC_ASSERT(lbl, clk, rst_n, prop)
`define IZPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/izpc_pkg.sv
// ---------------------------------------------------------------------------
// izpc_pkg
// Shared types and constants of the irrigation zone power controller.
// ---------------------------------------------------------------------------
package izpc_pkg;

	// zone count
	localparam int ZONES_DEF = 4;
	localparam int ZONES_MAX = 16;

	// field widths
	localparam int ZONE_IDX_W   = 4;
	localparam int ZONE_MASK_W  = 4;
	localparam int ZONE_TICKS_W = 18;
	localparam int IDLE_TICKS_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MAX  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 1'd1;

	localparam logic [ZONE_TICKS_W-1:0] ZONE_MAX_RST  = 18'd18000;
	localparam logic [IDLE_TICKS_W-1:0] OFF_DELAY_RST = 16'd600;

	// counter saturation points
	localparam logic [ZONE_TICKS_W-1:0] ZONE_TICKS_SAT = '1;
	localparam logic [IDLE_TICKS_W-1:0] IDLE_TICKS_SAT = '1;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_SET_ZONE  = 2'd1,
		OP_SET_LIGHT = 2'd2,
		OP_POWER_EN  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  rain_level;
		logic [ZONE_IDX_W-1:0] zone_index;
		logic                  switch_on;
	} cmd_t;

	typedef struct packed {
		logic                   power_on;
		logic                   light_on;
		logic [ZONE_MASK_W-1:0] zone_mask;
		logic                   rain_seen;
		logic                   zone_fused;
	} result_t;

endpackage

FILE: rtl/core/irrigation_zone_power_controller.sv
// A command word is captured in the input stage, its result in the result
// stage. Throughput: one word per cycle while out_stall is low; each stage holds
// one word, so input stall rises only when the result register is stalled.
// Reset: all valves, pump, light, timers and rain state clear; the zone
// timeout loads 18000 ticks and the pump off-delay 600 ticks.
// ---------------------------------------------------------------------------
// irrigation_zone_power_controller
// Valve, pump and light controller with tick-driven timers and safety fuse.
// ---------------------------------------------------------------------------
module irrigation_zone_power_controller #(
	parameter int ZONES = izpc_pkg::ZONES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic                                rain_level,
	input  logic [izpc_pkg::ZONE_IDX_W-1:0]     zone_index,
	input  logic                                switch_on,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                power_on,
	output logic                                light_on,
	output logic [izpc_pkg::ZONE_MASK_W-1:0]    zone_mask,
	output logic                                rain_seen,
	output logic                                zone_fused,
	input  logic                                cfg_we,
	input  logic [izpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [izpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                              valid_s1, valid_s2;
	izpc_pkg::cmd_t                    cmd_s1;
	izpc_pkg::result_t                 res_s2, res;
	logic                              adv, acc_in, fire;
	logic [izpc_pkg::ZONE_TICKS_W-1:0] zone_max_ticks;
	logic [izpc_pkg::IDLE_TICKS_W-1:0] power_off_delay_ticks;

	// handshake: the input stage moves on whenever the result stage frees
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign acc_in   = in_valid && !in_stall;
	assign fire     = valid_s1 && adv;

	// capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_s1.op         <= izpc_pkg::op_t'(op);
			cmd_s1.rain_level <= rain_level;
			cmd_s1.zone_index <= zone_index;
			cmd_s1.switch_on  <= switch_on;
		end
	end

	izpc_cfg_regs u_cfg (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.zone_max_ticks        (zone_max_ticks),
		.power_off_delay_ticks (power_off_delay_ticks)
	);

	izpc_core #(
		.ZONES (ZONES)
	) u_core (
		.clk                   (clk),
		.arst_n                (arst_n),
		.fire                  (fire),
		.cmd                   (cmd_s1),
		.zone_max_ticks        (zone_max_ticks),
		.power_off_delay_ticks (power_off_delay_ticks),
		.res                   (res)
	);

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign power_on   = res_s2.power_on;
	assign light_on   = res_s2.light_on;
	assign zone_mask  = res_s2.zone_mask;
	assign rain_seen  = res_s2.rain_seen;
	assign zone_fused = res_s2.zone_fused;

endmodule

FILE: rtl/core/izpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// izpc_cfg_regs
// Holds the zone timeout and the pump off-delay written over the config port.
// ---------------------------------------------------------------------------
module izpc_cfg_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [izpc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [izpc_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [izpc_pkg::ZONE_TICKS_W-1:0]      zone_max_ticks,
	output logic [izpc_pkg::IDLE_TICKS_W-1:0]      power_off_delay_ticks
);

	logic [izpc_pkg::ZONE_TICKS_W-1:0] zone_max_q;
	logic [izpc_pkg::IDLE_TICKS_W-1:0] off_delay_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_max_q  <= izpc_pkg::ZONE_MAX_RST;
			off_delay_q <= izpc_pkg::OFF_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				izpc_pkg::CFG_ZONE_MAX: begin
					zone_max_q <= cfg_data[izpc_pkg::ZONE_TICKS_W-1:0];
				end
				izpc_pkg::CFG_OFF_DELAY: begin
					off_delay_q <= cfg_data[izpc_pkg::IDLE_TICKS_W-1:0];
				end
			endcase
		end
	end

	assign zone_max_ticks        = zone_max_q;
	assign power_off_delay_ticks = off_delay_q;

endmodule

FILE: rtl/core/izpc_core.sv
// ---------------------------------------------------------------------------
// izpc_core
// Controller state and its single-pass update for one command word.
// ---------------------------------------------------------------------------
`include "irrigation_zone_power_controller_defines.svh"

module izpc_core #(
	parameter int ZONES = izpc_pkg::ZONES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  izpc_pkg::cmd_t                    cmd,
	input  logic [izpc_pkg::ZONE_TICKS_W-1:0] zone_max_ticks,
	input  logic [izpc_pkg::IDLE_TICKS_W-1:0] power_off_delay_ticks,
	output izpc_pkg::result_t                 res
);

	logic                              pump_q, pump_n;
	logic                              lamp_q, lamp_n;
	logic [ZONES-1:0]                  open_q, open_n;
	logic [ZONES-1:0]                  zone_sel;
	logic [izpc_pkg::ZONE_TICKS_W-1:0] zon_q, zon_n, zon_inc;
	logic                              armed_q, armed_n;
	logic [izpc_pkg::IDLE_TICKS_W-1:0] idle_q, idle_n, idle_inc;
	logic                              rain_q, rain_n;
	logic                              fused;
	logic                              any_open;

	// decode the addressed zone; an index past the last zone matches nothing
	always_comb begin
		for (int i = 0; i < ZONES; i++) begin
			zone_sel[i] = cmd.switch_on &&
				(cmd.zone_index == izpc_pkg::ZONE_IDX_W'(i));
		end
	end

	// saturating timer increments
	assign zon_inc  = (zon_q != izpc_pkg::ZONE_TICKS_SAT) ?
		zon_q + izpc_pkg::ZONE_TICKS_W'(1) : zon_q;
	assign idle_inc = (idle_q != izpc_pkg::IDLE_TICKS_SAT) ?
		idle_q + izpc_pkg::IDLE_TICKS_W'(1) : idle_q;
	assign any_open = |open_q;

	// next state for the command word
	always_comb begin
		pump_n  = pump_q;
		lamp_n  = lamp_q;
		open_n  = open_q;
		zon_n   = zon_q;
		armed_n = armed_q;
		idle_n  = idle_q;
		rain_n  = rain_q;
		fused   = 1'b0;
		unique case (cmd.op)
			izpc_pkg::OP_TICK: begin
				rain_n = cmd.rain_level;
				if (cmd.rain_level) begin
					pump_n  = 1'b0;
					armed_n = 1'b0;
					idle_n  = '0;
				end else if (!any_open) begin
					if (!armed_q) begin
						armed_n = 1'b1;
						idle_n  = '0;
					end else begin
						idle_n = idle_inc;
						if (idle_inc > power_off_delay_ticks) begin
							pump_n = 1'b0;
						end
					end
				end else begin
					pump_n  = 1'b1;
					armed_n = 1'b0;
					idle_n  = '0;
				end
				// safety fuse acts after the power decision
				if (any_open) begin
					if (zon_inc > zone_max_ticks) begin
						open_n = '0;
						zon_n  = '0;
						fused  = 1'b1;
					end else begin
						zon_n = zon_inc;
					end
				end
			end
			izpc_pkg::OP_SET_ZONE: begin
				open_n = zone_sel;
				zon_n  = '0;
			end
			izpc_pkg::OP_SET_LIGHT: begin
				lamp_n = cmd.switch_on;
			end
			izpc_pkg::OP_POWER_EN: begin
				pump_n = 1'b1;
			end
		endcase
	end

	// advance state on each word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q  <= 1'b0;
			lamp_q  <= 1'b0;
			open_q  <= '0;
			zon_q   <= '0;
			armed_q <= 1'b0;
			idle_q  <= '0;
			rain_q  <= 1'b0;
		end else if (fire) begin
			pump_q  <= pump_n;
			lamp_q  <= lamp_n;
			open_q  <= open_n;
			zon_q   <= zon_n;
			armed_q <= armed_n;
			idle_q  <= idle_n;
			rain_q  <= rain_n;
		end
	end

	// map the first zones onto the result mask
	genvar g;
	generate
		for (g = 0; g < izpc_pkg::ZONE_MASK_W; g++) begin : g_mask
			if (g < ZONES) begin : g_zone
				assign res.zone_mask[g] = open_n[g];
			end else begin : g_none
				assign res.zone_mask[g] = 1'b0;
			end
		end
	endgenerate

	assign res.power_on   = pump_n;
	assign res.light_on   = lamp_n;
	assign res.rain_seen  = rain_n;
	assign res.zone_fused = fused;

	// at most one valve is ever open
	`IZPC_ASSERT_ALWAYS(a_one_zone, clk, $onehot0(open_q))
	// a rainy tick always leaves the pump off
	`IZPC_ASSERT(a_rain_off, clk, arst_n,
		fire && cmd.op == izpc_pkg::OP_TICK && cmd.rain_level |=> !pump_q)
	// a fuse only fires on a tick with an open zone and closes all zones
	`IZPC_ASSERT(a_fuse, clk, arst_n,
		fire && fused |=> $past(any_open) && open_q == '0 && zon_q == '0)

endmodule
